// ===== rtl/core/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared constants, header layout and state codes of the pool allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned PoolBytes    = 65536;
  localparam int unsigned GranuleBytes = 16;
  localparam int unsigned HeaderBytes  = 32;
  localparam int unsigned MinBlkBytes  = 48;

  localparam int unsigned NumGran  = PoolBytes / GranuleBytes;
  localparam int unsigned Managed  = NumGran * GranuleBytes;
  localparam int unsigned HdrSpan  =
      ((HeaderBytes + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
  localparam int unsigned GranLog  = $clog2(GranuleBytes);
  localparam int unsigned IdxW     = $clog2(NumGran);
  // sizes and positions in bytes, wide enough for the managed size itself
  localparam int unsigned SzW      = $clog2(Managed) + 1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_ALLOC = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [SzW-1:0]    size;
    logic [SzW-1:0]    prev_size;
    logic [31:0]       tag;
  } hdr_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT_RD,
    S_A_SPLIT_WR,
    S_F_RD,
    S_F_CHK,
    S_F_NXT_CHK,
    S_F_NN_CHK,
    S_F_PRV_CHK,
    S_F_PN_CHK,
    S_F_CLR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic           we;
    logic [IdxW-1:0] waddr;
    hdr_t           wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/ffpa_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_hdr_ram
// per-granule header store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffpa_hdr_ram
  import ffpa_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output hdr_t     rdata_o
);

  hdr_t mem [NumGran];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ===== rtl/core/first_fit_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// first-fit byte pool allocator with boundary tags kept in a header memory
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  command  | opcode_i request_bytes_i owner_tag_i          | start_i, busy_o
//           | payload_offset_i                              |
//  result   | status_o granted_offset_o free_bytes_o        | done_o strobe
//           | total_bytes_o                                 |
//
// an allocate walks the block chain one header at a time (read then check),
// with a further read and write when it splits the found block; a free reads
// the block and its next and previous neighbours, and clears its header when
// it merges with the previous block; a rejected word strobes in the next
// cycle. the header memory gives one read and one write per cycle. after
// reset a clearing pass writes every header, busy_o high.
// one word at a time; the result strobe lasts one cycle and cannot be stalled.
module first_fit_pool_allocator
  import ffpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [16:0] request_bytes_i,
  input  logic [31:0] owner_tag_i,
  input  logic [15:0] payload_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] granted_offset_o,
  output logic [16:0] free_bytes_o,
  output logic [16:0] total_bytes_o
);

  state_e state_q, state_d;
  mem_req_t mreq;
  hdr_t rd;

  logic [IdxW-1:0] clr_q, clr_d;
  logic [SzW-1:0]  pos_q, pos_d;     // current block position
  logic [SzW-1:0]  need_q, need_d;
  logic [SzW-1:0]  aux_q, aux_d;     // split / neighbour position
  logic [SzW-1:0]  fsize_q, fsize_d; // size of block being freed / kept
  logic [SzW-1:0]  ppos_q, ppos_d;
  logic [31:0]     tag_q, tag_d;
  hdr_t            h_q, h_d;
  logic [SzW-1:0]  free_q, free_d;
  logic [1:0]      stat_q, stat_d;
  logic [15:0]     gnt_q, gnt_d;

  ffpa_hdr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rd)
  );

  function automatic logic [IdxW-1:0] gidx(input logic [SzW-1:0] p);
    gidx = p[GranLog +: IdxW];
  endfunction

  // request sizing
  logic [SzW+1:0] req_round;
  logic [SzW+1:0] req_need;
  logic [SzW-1:0] off_ext;
  logic [SzW-1:0] fpos;
  assign req_round = ({{(SzW+2-17){1'b0}}, request_bytes_i} + (SzW+2)'(GranuleBytes - 1))
                     & ~((SzW+2)'(GranuleBytes - 1));
  assign req_need  = req_round + (SzW+2)'(HdrSpan);
  assign off_ext   = SzW'(payload_offset_i);
  assign fpos      = off_ext - SzW'(HdrSpan);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      free_q  <= SzW'(Managed);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    need_q  <= need_d;
    aux_q   <= aux_d;
    fsize_q <= fsize_d;
    ppos_q  <= ppos_d;
    tag_q   <= tag_d;
    h_q     <= h_d;
    stat_q  <= stat_d;
    gnt_q   <= gnt_d;
  end

  logic [SzW-1:0] left;
  logic [SzW-1:0] nsum;
  assign left = rd.size - need_q;
  assign nsum = pos_q + fsize_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:      if (clr_q == IdxW'(NumGran - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          if (!opcode_i) begin
            if (request_bytes_i == '0 || req_need > (SzW+2)'(Managed)) state_d = S_DONE;
            else state_d = S_A_RD;
          end else begin
            if (payload_offset_i == '0 || off_ext < SzW'(HdrSpan) ||
                fpos >= SzW'(Managed) || fpos[GranLog-1:0] != '0) state_d = S_DONE;
            else state_d = S_F_RD;
          end
        end
      end
      S_A_RD:       state_d = S_A_CHK;
      S_A_CHK: begin
        if (rd.size == '0) state_d = S_DONE;
        else if (rd.kind == KIND_FREE && rd.size >= need_q) begin
          if (left >= SzW'(MinBlkBytes)) state_d = S_A_SPLIT_RD;
          else state_d = S_DONE;
        end else if (pos_q + rd.size >= SzW'(Managed)) state_d = S_DONE;
        else state_d = S_A_RD;
      end
      S_A_SPLIT_RD: state_d = S_A_SPLIT_WR;
      S_A_SPLIT_WR: state_d = S_DONE;
      S_F_RD:       state_d = S_F_CHK;
      S_F_CHK: begin
        if (rd.kind != KIND_ALLOC) state_d = S_DONE;
        else state_d = S_F_NXT_CHK;
      end
      S_F_NXT_CHK:  state_d = S_F_NN_CHK;
      S_F_NN_CHK:   state_d = S_F_PRV_CHK;
      S_F_PRV_CHK:  state_d = S_F_PN_CHK;
      S_F_PN_CHK: begin
        if (ppos_q != pos_q) state_d = S_F_CLR;
        else state_d = S_DONE;
      end
      S_F_CLR:      state_d = S_DONE;
      S_DONE:       state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_d   = clr_q;
    pos_d   = pos_q;
    need_d  = need_q;
    aux_d   = aux_q;
    fsize_d = fsize_q;
    ppos_d  = ppos_q;
    tag_d   = tag_q;
    h_d     = h_q;
    free_d  = free_q;
    stat_d  = stat_q;
    gnt_d   = gnt_q;
    mreq       = '0;
    mreq.raddr = gidx(pos_q);
    unique case (state_q)
      S_CLEAR: begin
        clr_d            = clr_q + 1'b1;
        mreq.we          = 1'b1;
        mreq.waddr       = clr_q;
        mreq.wdata       = '0;
        if (clr_q == '0) begin
          mreq.wdata.kind = KIND_FREE;
          mreq.wdata.size = SzW'(Managed);
        end
      end
      S_IDLE: begin
        stat_d = ST_DONE;
        gnt_d  = '0;
        tag_d  = owner_tag_i;
        need_d = SzW'(req_need);
        pos_d  = opcode_i ? fpos : '0;
        if (!opcode_i) begin
          if (request_bytes_i == '0 || req_need > (SzW+2)'(Managed)) stat_d = ST_FAIL;
        end else if (payload_offset_i == '0) stat_d = ST_FAIL;
        else if (off_ext < SzW'(HdrSpan) || fpos >= SzW'(Managed) ||
                 fpos[GranLog-1:0] != '0) stat_d = ST_BADFREE;
      end
      S_A_CHK: begin
        if (rd.size == '0) stat_d = ST_FAIL;
        else if (rd.kind == KIND_FREE && rd.size >= need_q) begin
          h_d       = rd;
          h_d.kind  = KIND_ALLOC;
          h_d.tag   = tag_q;
          gnt_d     = 16'(pos_q + SzW'(HdrSpan));
          aux_d     = pos_q + need_q;
          fsize_d   = left;
          if (left >= SzW'(MinBlkBytes)) begin
            h_d.size = need_q;
            free_d   = free_q - need_q;
            // write the split-off free block now
            mreq.we              = 1'b1;
            mreq.waddr           = gidx(pos_q + need_q);
            mreq.wdata.kind      = KIND_FREE;
            mreq.wdata.size      = left;
            mreq.wdata.prev_size = need_q;
            mreq.wdata.tag       = '0;
          end else begin
            free_d     = free_q - rd.size;
            mreq.we    = 1'b1;
            mreq.waddr = gidx(pos_q);
            mreq.wdata = h_d;
          end
        end else begin
          pos_d = pos_q + rd.size;
          mreq.raddr = gidx(pos_q + rd.size);
          if (pos_q + rd.size >= SzW'(Managed)) stat_d = ST_FAIL;
        end
      end
      S_A_SPLIT_RD: begin
        // write allocated head, read the block after the split tail
        mreq.we    = 1'b1;
        mreq.waddr = gidx(pos_q);
        mreq.wdata = h_q;
        mreq.raddr = gidx(aux_q + fsize_q);
      end
      S_A_SPLIT_WR: begin
        if (aux_q + fsize_q < SzW'(Managed)) begin
          mreq.we              = 1'b1;
          mreq.waddr           = gidx(aux_q + fsize_q);
          mreq.wdata           = rd;
          mreq.wdata.prev_size = fsize_q;
        end
      end
      S_F_CHK: begin
        h_d      = rd;
        h_d.kind = KIND_FREE;
        h_d.tag  = '0;
        fsize_d  = rd.size;
        if (rd.kind != KIND_ALLOC) stat_d = ST_BADFREE;
        else free_d = free_q + rd.size;
        mreq.raddr = gidx(pos_q + rd.size);
      end
      S_F_NXT_CHK: begin
        // rd = next neighbour
        if (nsum < SzW'(Managed) && rd.kind == KIND_FREE) begin
          h_d.size   = fsize_q + rd.size;
          fsize_d    = fsize_q + rd.size;
          mreq.we    = 1'b1;
          mreq.waddr = gidx(nsum);
          mreq.wdata = '0;
          mreq.raddr = gidx(nsum + rd.size);
        end else begin
          mreq.raddr = gidx(nsum);
        end
      end
      S_F_NN_CHK: begin
        // rd = block after merged block: fix its previous size
        if (nsum < SzW'(Managed)) begin
          mreq.we              = 1'b1;
          mreq.waddr           = gidx(nsum);
          mreq.wdata           = rd;
          mreq.wdata.prev_size = fsize_q;
        end
        ppos_d     = pos_q - h_q.prev_size;
        mreq.raddr = gidx(pos_q - h_q.prev_size);
      end
      S_F_PRV_CHK: begin
        // rd = previous neighbour
        aux_d = nsum;
        if (h_q.prev_size != '0 && h_q.prev_size <= pos_q && rd.kind == KIND_FREE) begin
          mreq.we         = 1'b1;
          mreq.waddr      = gidx(ppos_q);
          mreq.wdata      = rd;
          mreq.wdata.size = rd.size + fsize_q;
          stat_d          = ST_DONE;
          h_d             = '0;
          fsize_d         = rd.size + fsize_q;
        end else begin
          mreq.we    = 1'b1;
          mreq.waddr = gidx(pos_q);
          mreq.wdata = h_q;
          ppos_d     = pos_q;
        end
        mreq.raddr = gidx(nsum);
      end
      S_F_PN_CHK: begin
        // fix prev_size of the block after the merged block
        if (aux_q < SzW'(Managed)) begin
          mreq.we              = 1'b1;
          mreq.waddr           = gidx(aux_q);
          mreq.wdata           = rd;
          mreq.wdata.prev_size = fsize_q;
        end
      end
      S_F_CLR: begin
        // header absorbed by the previous block
        mreq.we    = 1'b1;
        mreq.waddr = gidx(pos_q);
        mreq.wdata = '0;
      end
      default: ;
    endcase
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign status_o         = stat_q;
  assign granted_offset_o = gnt_q;
  assign free_bytes_o     = 17'(free_q);
  assign total_bytes_o    = 17'(Managed);

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= SzW'(Managed)) else $error("free count overflow");
  a_gnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_DONE |-> granted_offset_o == '0)
    else $error("grant on failure");

endmodule
